[rtl/core/kpg_pkg.sv]
package kpg_pkg;

  // pending count width, signed
  localparam int PENDING_BITS = 16;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [15:0] LONG_RST      = 16'd300;
  localparam logic [15:0] PULSE_RST     = 16'd6;
  localparam logic [15:0] GAP_RST       = 16'd26;
  localparam logic [15:0] AWAKE_RST     = 16'd10000;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_LONG     = 3'd1,
    REG_PULSE    = 3'd2,
    REG_GAP      = 3'd3,
    REG_AWAKE    = 3'd4
  } reg_idx_t;

  typedef logic signed [PENDING_BITS-1:0] pend_t;
  typedef logic signed [PENDING_BITS:0]   pend_w_t;

  localparam pend_w_t PEND_LIM = pend_w_t'((64'sd1 <<< (PENDING_BITS - 1)) - 64'sd1);
  localparam pend_w_t PEND_NEG_LIM = -PEND_LIM;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] pulse_ms;
    logic [15:0] gap_ms;
    logic [15:0] awake_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        enc_a;
    logic        enc_b;
    logic        button_level;
    logic        alt_mode;
    logic        hold_awake;
  } item_t;

  typedef struct packed {
    logic rot_edge;
    logic incr_key;
    logic decr_key;
    logic alt_valid;
    logic alt_up;
  } rot_res_t;

  typedef struct packed {
    logic press;
    logic long_ev;
    logic button_key;
  } btn_res_t;

  // wrapping elapsed time, strictly greater than limit
  function automatic logic expired(logic [31:0] now, logic [31:0] mark, logic [15:0] limit);
    logic [31:0] d;
    d = now - mark;
    return d > {16'd0, limit};
  endfunction

  // +/-1 with symmetric saturation
  function automatic pend_t pend_step(pend_t v, logic up);
    pend_w_t w;
    w = pend_w_t'(v) + (up ? pend_w_t'(1) : pend_w_t'(-1));
    if (w > PEND_LIM) w = PEND_LIM;
    if (w < PEND_NEG_LIM) w = PEND_NEG_LIM;
    return pend_t'(w);
  endfunction

endpackage

[rtl/core/kpg_rot.sv]
module kpg_rot (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  kpg_pkg::item_t   item,
  input  kpg_pkg::cfg_t    cfg,
  output kpg_pkg::rot_res_t res
);
  import kpg_pkg::*;

  logic        last_a;
  pend_t       pending_steps;
  logic        incr_active;
  logic        decr_active;
  logic [31:0] rot_pulse_start;
  logic [31:0] rot_gap_start;

  pend_t       pending_steps_next;
  logic        incr_active_next;
  logic        decr_active_next;
  logic [31:0] rot_pulse_start_next;
  logic [31:0] rot_gap_start_next;

  always_comb begin
    pend_t pend1;
    logic  inc1;
    logic  dec1;
    logic  [31:0] ps1;

    res = '0;
    res.rot_edge = !item.enc_a && last_a;
    pend1 = pending_steps;
    if (res.rot_edge) begin
      if (!item.alt_mode) begin
        pend1 = pend_step(pending_steps, item.enc_b);
      end else begin
        res.alt_valid = 1'b1;
        res.alt_up    = item.enc_b;
      end
    end

    inc1 = incr_active;
    dec1 = decr_active;
    ps1  = rot_pulse_start;
    if (pend1 != '0 && !incr_active && !decr_active &&
        expired(item.now_ms, rot_gap_start, cfg.gap_ms)) begin
      if (pend1 > 0) inc1 = 1'b1;
      else dec1 = 1'b1;
      ps1 = item.now_ms;
    end

    pending_steps_next   = pend1;
    incr_active_next     = inc1;
    decr_active_next     = dec1;
    rot_pulse_start_next = ps1;
    rot_gap_start_next   = rot_gap_start;
    if (inc1 && expired(item.now_ms, ps1, cfg.pulse_ms)) begin
      rot_gap_start_next = item.now_ms;
      incr_active_next   = 1'b0;
      pending_steps_next = pend_step(pend1, 1'b0);
    end else if (dec1 && expired(item.now_ms, ps1, cfg.pulse_ms)) begin
      rot_gap_start_next = item.now_ms;
      decr_active_next   = 1'b0;
      pending_steps_next = pend_step(pend1, 1'b1);
    end

    res.incr_key = incr_active_next;
    res.decr_key = decr_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_a          <= 1'b1;
      pending_steps   <= '0;
      incr_active     <= 1'b0;
      decr_active     <= 1'b0;
      rot_pulse_start <= '0;
      rot_gap_start   <= '0;
    end else if (step) begin
      last_a          <= item.enc_a;
      pending_steps   <= pending_steps_next;
      incr_active     <= incr_active_next;
      decr_active     <= decr_active_next;
      rot_pulse_start <= rot_pulse_start_next;
      rot_gap_start   <= rot_gap_start_next;
    end
  end

endmodule

[rtl/core/kpg_btn.sv]
module kpg_btn (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  kpg_pkg::item_t   item,
  input  kpg_pkg::cfg_t    cfg,
  output kpg_pkg::btn_res_t res
);
  import kpg_pkg::*;

  logic        btn_held;
  logic        btn_long_done;
  logic        btn_pulse_active;
  logic [31:0] btn_time_mark;
  logic [31:0] btn_release_time;

  logic        btn_held_next;
  logic        btn_long_done_next;
  logic        btn_pulse_active_next;
  logic [31:0] btn_time_mark_next;
  logic [31:0] btn_release_time_next;

  always_comb begin
    logic        held1;
    logic        done1;
    logic [31:0] mark1;

    res = '0;
    res.press = !btn_held && !item.button_level &&
                expired(item.now_ms, btn_release_time, cfg.debounce_ms);
    held1 = btn_held | res.press;
    mark1 = res.press ? item.now_ms : btn_time_mark;

    res.long_ev = held1 && !btn_long_done &&
                  expired(item.now_ms, mark1, cfg.long_press_ms);
    done1 = btn_long_done | res.long_ev;

    btn_held_next         = held1;
    btn_long_done_next    = done1;
    btn_pulse_active_next = btn_pulse_active;
    btn_time_mark_next    = mark1;
    btn_release_time_next = btn_release_time;
    if (held1 && item.button_level) begin
      btn_held_next = 1'b0;
      if (!done1) begin
        btn_pulse_active_next = 1'b1;
        btn_time_mark_next    = item.now_ms;
      end
      btn_long_done_next    = 1'b0;
      btn_release_time_next = item.now_ms;
    end

    if (btn_pulse_active_next &&
        expired(item.now_ms, btn_time_mark_next, cfg.pulse_ms)) begin
      btn_pulse_active_next = 1'b0;
    end
    res.button_key = btn_pulse_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_held         <= 1'b0;
      btn_long_done    <= 1'b0;
      btn_pulse_active <= 1'b0;
      btn_time_mark    <= '0;
      btn_release_time <= '0;
    end else if (step) begin
      btn_held         <= btn_held_next;
      btn_long_done    <= btn_long_done_next;
      btn_pulse_active <= btn_pulse_active_next;
      btn_time_mark    <= btn_time_mark_next;
      btn_release_time <= btn_release_time_next;
    end
  end

endmodule

[rtl/core/knob_to_key_pulse_generator_core.sv]
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  now_ms[32] enc_a enc_b button_level alt_mode hold_awake
// out      source     out_valid/ out_stall incr_key decr_key button_key alt_step_valid
//                                          alt_step_up long_press sleep_request
// cfg      sink       cfg_valid/ cfg_ready cfg_index[3] cfg_data[16]
//
// One word per clock while out_stall is low; a word that is taken loads the input
// register, and its result then loads the result register, from which it leaves.
// The whole sample update sits in one combinational pass between those registers.
// Reset (synchronous) loads register defaults and clears all knob state.
// out_stall holds the result register; in_stall rises only when the input
// register is full behind a stalled result.
module knob_to_key_pulse_generator_core (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        enc_a,
  input  logic        enc_b,
  input  logic        button_level,
  input  logic        alt_mode,
  input  logic        hold_awake,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        incr_key,
  output logic        decr_key,
  output logic        button_key,
  output logic        alt_step_valid,
  output logic        alt_step_up,
  output logic        long_press,
  output logic        sleep_request,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kpg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import kpg_pkg::*;

  cfg_t     cfg;
  item_t    s0_item;
  logic     s0_valid;
  logic     adv;
  logic     step;
  rot_res_t rot_res;
  btn_res_t btn_res;

  // idle timer
  logic        idle_running;
  logic [31:0] idle_start;
  logic        idle_running_next;
  logic [31:0] idle_start_next;
  logic        sleep_now;

  assign cfg_ready = 1'b1;

  // result register free or being drained this edge
  assign adv      = !out_valid || !out_stall;
  assign step     = s0_valid && adv;
  assign in_stall = s0_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DEBOUNCE_RST;
      cfg.long_press_ms <= LONG_RST;
      cfg.pulse_ms      <= PULSE_RST;
      cfg.gap_ms        <= GAP_RST;
      cfg.awake_ms      <= AWAKE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ms   <= cfg_data;
        REG_LONG:     cfg.long_press_ms <= cfg_data;
        REG_PULSE:    cfg.pulse_ms      <= cfg_data;
        REG_GAP:      cfg.gap_ms        <= cfg_data;
        REG_AWAKE:    cfg.awake_ms      <= cfg_data;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= (in_valid && !in_stall) || (s0_valid && !adv);
    end
    if (in_valid && !in_stall) begin
      s0_item.now_ms       <= now_ms;
      s0_item.enc_a        <= enc_a;
      s0_item.enc_b        <= enc_b;
      s0_item.button_level <= button_level;
      s0_item.alt_mode     <= alt_mode;
      s0_item.hold_awake   <= hold_awake;
    end
  end

  kpg_rot u_rot (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s0_item),
    .cfg  (cfg),
    .res  (rot_res)
  );

  kpg_btn u_btn (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s0_item),
    .cfg  (cfg),
    .res  (btn_res)
  );

  // Timer starts on any sample without hold_awake; the request is judged on
  // the started timer, then a press or rotation edge stops it again.
  always_comb begin
    logic run1;
    run1            = idle_running || !s0_item.hold_awake;
    idle_start_next = idle_running ? idle_start : s0_item.now_ms;
    sleep_now       = run1 && expired(s0_item.now_ms, idle_start_next, cfg.awake_ms);
    idle_running_next = run1 && !btn_res.press && !rot_res.rot_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_running <= 1'b0;
      idle_start   <= '0;
    end else if (step) begin
      idle_running <= idle_running_next;
      idle_start   <= idle_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s0_valid;
    end
    if (step) begin
      incr_key       <= rot_res.incr_key;
      decr_key       <= rot_res.decr_key;
      button_key     <= btn_res.button_key;
      alt_step_valid <= rot_res.alt_valid;
      alt_step_up    <= rot_res.alt_up;
      long_press     <= btn_res.long_ev;
      sleep_request  <= sleep_now;
    end
  end

endmodule

[rtl/core/kpg_checker.sv]
module kpg_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic incr_key,
  input logic decr_key,
  input logic alt_step_valid,
  input logic alt_step_up
);

  // input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // only one rotation key can be active at a time
  a_one_key: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(incr_key && decr_key))
    else $error("incr_key and decr_key both high");

  a_alt_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alt_step_up) |-> alt_step_valid)
    else $error("alt_step_up without alt_step_valid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(incr_key) && $stable(decr_key)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind knob_to_key_pulse_generator_core kpg_checker u_kpg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .incr_key       (incr_key),
  .decr_key       (decr_key),
  .alt_step_valid (alt_step_valid),
  .alt_step_up    (alt_step_up)
);
